>>> hdl/trtcm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, constants and types of the two-rate three-color marker.
package trtcm_pkg;

  localparam int unsigned RateW    = 37;
  localparam int unsigned BurstW   = 24;
  localparam int unsigned TokW     = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned BytesW   = 16;
  localparam int unsigned ColorW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 37;
  localparam int unsigned EarnW    = TokW + 1;
  localparam int unsigned EarnLat  = 5;

  // floor(x / 8000000) = floor(floor(x / 2^9) / 15625)
  localparam int unsigned ByteShift  = 9;
  localparam int unsigned NumW       = 38;
  localparam int unsigned RecipW     = 39;
  localparam int unsigned RecipShift = 52;
  localparam logic [RecipW-1:0] RecipMul = 39'd288230376152;
  localparam logic [NumW-1:0]   SatLimit = 38'd262144000000;

  typedef enum logic [ColorW-1:0] {
    ColorGreen  = 2'd0,
    ColorYellow = 2'd1,
    ColorRed    = 2'd2
  } color_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeakRate       = 3'd0,
    RegPeakBurst      = 3'd1,
    RegCommittedRate  = 3'd2,
    RegCommittedBurst = 3'd3,
    RegUpdateInterval = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              peak_we;
    logic              committed_we;
    logic [BurstW-1:0] data;
  } burst_wr_t;

endpackage

>>> hdl/trtcm_if.sv
`timescale 1ns / 1ps
// Input and output channel interfaces of the marker.
interface trtcm_in_if;
  import trtcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  now_ticks;
  logic [BytesW-1:0] packet_bytes;

  modport source (output valid, output now_ticks, output packet_bytes, input ready);
  modport sink   (input valid, input now_ticks, input packet_bytes, output ready);
endinterface

interface trtcm_out_if;
  import trtcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

>>> hdl/two_rate_three_color_marker_core.sv
`timescale 1ns / 1ps
// A color reaches the output after the s0, s1 and credit multiplier registers and the queue.
// Throughput: one transfer per cycle unless stalled; 5-stage credit multiplier, no feedback.
// Input ready drops only while FifoDepth items are in flight or queued at the output.
// Async active-low reset rst_ni clears config, valid bits, buckets, refill time, queue.
// Refill time and bucket levels each close their loop through a single register.
module two_rate_three_color_marker_core #(
  parameter int unsigned FifoDepth = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  trtcm_in_if.sink                       in_i,
  trtcm_out_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [trtcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [trtcm_pkg::CfgDataW-1:0] cfg_data_i
);
  import trtcm_pkg::*;

  logic [RateW-1:0]  peak_rate_q, committed_rate_q;
  logic [TimeW-1:0]  interval_q, last_q;
  burst_wr_t         burst_wr;
  logic              in_fire, in_ready;
  logic              s0_valid_q, s1_valid_q;
  logic [TimeW-1:0]  s0_now_q, elapsed, s1_elapsed_q;
  logic [BytesW-1:0] s0_bytes_q, s1_bytes_q;
  logic              refill;
  logic [EarnLat-1:0] vld_pipe_q;
  logic [BytesW-1:0] bytes_pipe_q [EarnLat];
  logic [EarnW-1:0]  peak_earned, committed_earned;
  logic [ColorW-1:0] color;

  assign in_ready    = in_i.ready;
  assign in_fire     = in_i.valid && in_ready;

  always_comb begin
    burst_wr.peak_we      = cfg_we_i && (cfg_idx_i == RegPeakBurst);
    burst_wr.committed_we = cfg_we_i && (cfg_idx_i == RegCommittedBurst);
    burst_wr.data         = cfg_data_i[BurstW-1:0];
    elapsed               = s0_now_q - last_q;
    refill                = (elapsed > interval_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_rate_q      <= '0;
      committed_rate_q <= '0;
      interval_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPeakRate:       peak_rate_q      <= cfg_data_i[RateW-1:0];
        RegCommittedRate:  committed_rate_q <= cfg_data_i[RateW-1:0];
        RegUpdateInterval: interval_q       <= cfg_data_i[TimeW-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      last_q     <= '0;
      vld_pipe_q <= '0;
    end else begin
      s0_valid_q <= in_fire;
      s1_valid_q <= s0_valid_q;
      if (s0_valid_q && refill) begin
        last_q <= s0_now_q;
      end
      vld_pipe_q <= {vld_pipe_q[EarnLat-2:0], s1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_now_q   <= in_i.now_ticks;
      s0_bytes_q <= in_i.packet_bytes;
    end
    s1_elapsed_q    <= refill ? elapsed : '0;
    s1_bytes_q      <= s0_bytes_q;
    bytes_pipe_q[0] <= s1_bytes_q;
    for (int i = 1; i < EarnLat; i++) begin
      bytes_pipe_q[i] <= bytes_pipe_q[i-1];
    end
  end

  trtcm_earn u_peak_earn (
    .clk_i     (clk_i),
    .rate_i    (peak_rate_q),
    .elapsed_i (s1_elapsed_q),
    .earned_o  (peak_earned)
  );

  trtcm_earn u_committed_earn (
    .clk_i     (clk_i),
    .rate_i    (committed_rate_q),
    .elapsed_i (s1_elapsed_q),
    .earned_o  (committed_earned)
  );

  trtcm_marker u_marker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .burst_wr_i         (burst_wr),
    .valid_i            (vld_pipe_q[EarnLat-1]),
    .bytes_i            (bytes_pipe_q[EarnLat-1]),
    .peak_earned_i      (peak_earned),
    .committed_earned_i (committed_earned),
    .color_o            (color)
  );

  trtcm_ofifo #(
    .Depth (FifoDepth)
  ) u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_ready_o  (in_i.ready),
    .wr_i        (vld_pipe_q[EarnLat-1]),
    .wr_color_i  (color),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_color_o (out_o.color)
  );

endmodule

>>> hdl/trtcm_earn.sv
`timescale 1ns / 1ps
// Pipelined token credit: min(floor(rate * elapsed / 8000000), 2^24).
module trtcm_earn (
  input  logic                           clk_i,
  input  logic [trtcm_pkg::RateW-1:0]    rate_i,
  input  logic [trtcm_pkg::TimeW-1:0]    elapsed_i,
  output logic [trtcm_pkg::EarnW-1:0]    earned_o
);
  import trtcm_pkg::*;

  localparam int unsigned RateLoW = 18;
  localparam int unsigned RateHiW = RateW - RateLoW;
  localparam int unsigned PpLoW   = RateLoW + TimeW;
  localparam int unsigned PpHiW   = RateHiW + TimeW;
  localparam int unsigned ProdW   = RateW + TimeW;
  localparam int unsigned ShW     = ProdW - ByteShift;
  localparam int unsigned NLoW    = 19;
  localparam int unsigned NHiW    = NumW - NLoW;
  localparam int unsigned MLoW    = 20;
  localparam int unsigned MHiW    = RecipW - MLoW;
  localparam int unsigned P00W    = NLoW + MLoW;
  localparam int unsigned P01W    = NLoW + MHiW;
  localparam int unsigned P10W    = NHiW + MLoW;
  localparam int unsigned P11W    = NHiW + MHiW;
  localparam int unsigned LoW     = NLoW + RecipW;
  localparam int unsigned HiW     = NHiW + RecipW;
  localparam int unsigned SumW    = NumW + RecipW;
  localparam logic [MLoW-1:0] MLo = RecipMul[MLoW-1:0];
  localparam logic [MHiW-1:0] MHi = RecipMul[RecipW-1:MLoW];

  logic [PpLoW-1:0] pp_lo_q;
  logic [PpHiW-1:0] pp_hi_q;
  logic [ProdW-1:0] prod;
  logic [ShW-1:0]   num;
  logic [NumW-1:0]  n_q;
  logic             sat_q, sat3_q, sat4_q;
  logic [P00W-1:0]  p00_q;
  logic [P01W-1:0]  p01_q;
  logic [P10W-1:0]  p10_q;
  logic [P11W-1:0]  p11_q;
  logic [LoW-1:0]   lo_q;
  logic [HiW-1:0]   hi_q;
  logic [SumW-1:0]  total;
  logic [EarnW-1:0] earned_d, earned_q;

  always_comb begin
    prod     = ProdW'(pp_lo_q) + {pp_hi_q, RateLoW'(0)};
    num      = prod[ProdW-1:ByteShift];
    total    = SumW'(lo_q) + {hi_q, NLoW'(0)};
    earned_d = sat4_q ? {1'b1, TokW'(0)} : {1'b0, total[RecipShift +: TokW]};
  end

  always_ff @(posedge clk_i) begin
    pp_lo_q  <= PpLoW'(rate_i[RateLoW-1:0]) * PpLoW'(elapsed_i);
    pp_hi_q  <= PpHiW'(rate_i[RateW-1:RateLoW]) * PpHiW'(elapsed_i);
    n_q      <= num[NumW-1:0];
    sat_q    <= (|num[ShW-1:NumW]) || (num[NumW-1:0] >= SatLimit);
    p00_q    <= P00W'(n_q[NLoW-1:0]) * P00W'(MLo);
    p01_q    <= P01W'(n_q[NLoW-1:0]) * P01W'(MHi);
    p10_q    <= P10W'(n_q[NumW-1:NLoW]) * P10W'(MLo);
    p11_q    <= P11W'(n_q[NumW-1:NLoW]) * P11W'(MHi);
    sat3_q   <= sat_q;
    lo_q     <= LoW'(p00_q) + {p01_q, MLoW'(0)};
    hi_q     <= HiW'(p10_q) + {p11_q, MLoW'(0)};
    sat4_q   <= sat3_q;
    earned_q <= earned_d;
  end

  assign earned_o = earned_q;

endmodule

>>> hdl/trtcm_marker.sv
`timescale 1ns / 1ps
// Token buckets, burst registers and color decision.
module trtcm_marker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  trtcm_pkg::burst_wr_t         burst_wr_i,
  input  logic                         valid_i,
  input  logic [trtcm_pkg::BytesW-1:0] bytes_i,
  input  logic [trtcm_pkg::EarnW-1:0]  peak_earned_i,
  input  logic [trtcm_pkg::EarnW-1:0]  committed_earned_i,
  output logic [trtcm_pkg::ColorW-1:0] color_o
);
  import trtcm_pkg::*;

  localparam int unsigned SumW = TokW + 2;

  logic [BurstW-1:0] peak_burst_q, committed_burst_q;
  logic [TokW-1:0]   peak_tok_q, peak_tok_d, committed_tok_q, committed_tok_d;
  logic [SumW-1:0]   peak_sum, committed_sum;
  logic [TokW-1:0]   peak_fill, committed_fill, bytes_ext;
  color_e            color;

  always_comb begin
    peak_sum       = SumW'(peak_tok_q) + SumW'(peak_earned_i);
    committed_sum  = SumW'(committed_tok_q) + SumW'(committed_earned_i);
    peak_fill      = (peak_sum > SumW'(peak_burst_q)) ? peak_burst_q : peak_sum[TokW-1:0];
    committed_fill = (committed_sum > SumW'(committed_burst_q)) ?
                     committed_burst_q : committed_sum[TokW-1:0];
    bytes_ext      = TokW'(bytes_i);
    if (peak_fill < bytes_ext) begin
      color           = ColorRed;
      peak_tok_d      = peak_fill;
      committed_tok_d = committed_fill;
    end else if (committed_fill < bytes_ext) begin
      color           = ColorYellow;
      peak_tok_d      = peak_fill - bytes_ext;
      committed_tok_d = committed_fill;
    end else begin
      color           = ColorGreen;
      peak_tok_d      = peak_fill - bytes_ext;
      committed_tok_d = committed_fill - bytes_ext;
    end
  end

  assign color_o = color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_burst_q <= '0;
      peak_tok_q   <= '0;
    end else if (burst_wr_i.peak_we) begin
      peak_burst_q <= burst_wr_i.data;
      peak_tok_q   <= burst_wr_i.data;
    end else if (valid_i) begin
      peak_tok_q   <= peak_tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_burst_q <= '0;
      committed_tok_q   <= '0;
    end else if (burst_wr_i.committed_we) begin
      committed_burst_q <= burst_wr_i.data;
      committed_tok_q   <= burst_wr_i.data;
    end else if (valid_i) begin
      committed_tok_q   <= committed_tok_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) peak_tok_q <= peak_burst_q)
    else $error("peak bucket above its burst size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed_tok_q <= committed_burst_q)
    else $error("committed bucket above its burst size");

endmodule

>>> hdl/trtcm_ofifo.sv
`timescale 1ns / 1ps
// Result queue with in-flight credit count that drives input ready.
module trtcm_ofifo #(
  parameter int unsigned Depth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_fire_i,
  output logic                         in_ready_o,
  input  logic                         wr_i,
  input  logic [trtcm_pkg::ColorW-1:0] wr_color_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [trtcm_pkg::ColorW-1:0] out_color_o
);
  import trtcm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ColorW-1:0] mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d, credit_q, credit_d;
  logic              out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign out_color_o = mem[rd_ptr_q];
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (credit_q < CntW'(Depth));

  always_comb begin
    case ({wr_i, out_fire})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
    case ({in_fire_i, out_fire})
      2'b10:   credit_d = credit_q + CntW'(1);
      2'b01:   credit_d = credit_q - CntW'(1);
      default: credit_d = credit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_ptr_q] <= wr_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      credit_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      credit_q <= credit_d;
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (out_fire) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= credit_q)
    else $error("queue holds more results than items in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> cnt_q < credit_q)
    else $error("result written with no item in flight");

endmodule

>>> tb/sv/tb_two_rate_three_color_marker_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-rate three-color marker core.
module tb_two_rate_three_color_marker_core;
  import trtcm_pkg::*;

  localparam int unsigned BitsPerByteUs = 8000000;
  localparam int unsigned PipeLatency   = 7;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned NumPhases     = 11;
  localparam int unsigned PhaseItems    = 150;
  localparam longint unsigned RateMax   = 64'h1F_FFFF_FFFF;
  localparam longint unsigned BurstMax  = 64'hFF_FFFF;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd5;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  trtcm_in_if  pkt_in ();
  trtcm_out_if color_out ();

  two_rate_three_color_marker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pkt_in),
    .out_o      (color_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // policer state mirror
  logic [RateW-1:0]  peak_rate_q;
  logic [RateW-1:0]  committed_rate_q;
  logic [BurstW-1:0] peak_burst_q;
  logic [BurstW-1:0] committed_burst_q;
  logic [TimeW-1:0]  interval_q;
  logic [TokW-1:0]   peak_tok_q;
  logic [TokW-1:0]   committed_tok_q;
  logic [TimeW-1:0]  last_refill_q;

  color_e      pending_colors[$];
  color_e      want_color;
  int unsigned mismatches;
  bit          src_gaps;
  bit          snk_gaps;
  bit          hold_req;
  bit          sink_took;
  int unsigned sink_wait;
  int unsigned stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TokW-1:0] refill_bucket(input logic [TokW-1:0] level,
                                                    input logic [BurstW-1:0] cap,
                                                    input logic [RateW-1:0] rate,
                                                    input logic [TimeW-1:0] dt);
    logic [69:0] credit;
    credit = (70'(rate) * 70'(dt)) / 70'(BitsPerByteUs);
    credit = credit + 70'(level);
    return (credit > 70'(cap)) ? cap : credit[TokW-1:0];
  endfunction

  function automatic color_e mark_packet(input logic [TimeW-1:0] now,
                                         input logic [BytesW-1:0] len);
    logic [TimeW-1:0] dt;
    dt = now - last_refill_q;
    if (dt > interval_q) begin
      last_refill_q   = now;
      peak_tok_q      = refill_bucket(peak_tok_q, peak_burst_q, peak_rate_q, dt);
      committed_tok_q = refill_bucket(committed_tok_q, committed_burst_q, committed_rate_q, dt);
    end
    if (peak_tok_q < TokW'(len)) return ColorRed;
    peak_tok_q = peak_tok_q - TokW'(len);
    if (committed_tok_q < TokW'(len)) return ColorYellow;
    committed_tok_q = committed_tok_q - TokW'(len);
    return ColorGreen;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegPeakRate:       peak_rate_q = val[RateW-1:0];
      RegPeakBurst: begin
        peak_burst_q = val[BurstW-1:0];
        peak_tok_q   = val[BurstW-1:0];
      end
      RegCommittedRate:  committed_rate_q = val[RateW-1:0];
      RegCommittedBurst: begin
        committed_burst_q = val[BurstW-1:0];
        committed_tok_q   = val[BurstW-1:0];
      end
      RegUpdateInterval: interval_q = val[TimeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic offer_packet(input logic [TimeW-1:0] t, input logic [BytesW-1:0] len);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      pkt_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pkt_in.valid        <= 1'b1;
    pkt_in.now_ticks    <= t;
    pkt_in.packet_bytes <= len;
    do @(posedge clk_i); while (!pkt_in.ready);
    pending_colors.push_back(mark_packet(t, len));
    @(negedge clk_i);
  endtask

  // drop valid, wait out every pending color and the pipeline tail
  task automatic settle_pipeline();
    pkt_in.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 3) @(negedge clk_i);
  endtask

  task automatic program_profile(output int unsigned pkt_max, output int unsigned step_max);
    longint unsigned bpu;
    longint unsigned peak;
    longint unsigned committed;
    longint unsigned pburst;
    longint unsigned cburst;
    case ($urandom_range(0, 3))
      0:       pkt_max = 64;
      1:       pkt_max = 1500;
      2:       pkt_max = 9000;
      default: pkt_max = 65535;
    endcase
    step_max  = $urandom_range(1, 50);
    bpu       = 64'(pkt_max) * $urandom_range(25, 75) / (100 * (step_max / 2 + 1));
    peak      = bpu * BitsPerByteUs + $urandom_range(0, BitsPerByteUs - 1);
    if (peak > RateMax) peak = RateMax;
    committed = peak * $urandom_range(0, 100) / 100;
    pburst    = 64'(pkt_max) * $urandom_range(1, 16);
    cburst    = 64'(pkt_max) * $urandom_range(0, 8);
    if (pburst > BurstMax) pburst = BurstMax;
    if (cburst > BurstMax) cburst = BurstMax;
    write_reg(RegPeakRate, CfgDataW'(peak));
    write_reg(RegCommittedRate, CfgDataW'(committed));
    write_reg(RegPeakBurst, {13'($urandom), 24'(pburst)});
    write_reg(RegCommittedBurst, {13'($urandom), 24'(cburst)});
    if ($urandom_range(0, 2) == 0)
      write_reg(RegUpdateInterval, '0);
    else
      write_reg(RegUpdateInterval, {5'($urandom), 32'($urandom_range(0, 2 * step_max))});
  endtask

  task automatic test_reset_state();
    offer_packet(32'd0, 16'd0);
    offer_packet(32'd0, 16'd1);
    offer_packet(32'd0, 16'hFFFF);
  endtask

  task automatic test_color_marking();
    settle_pipeline();
    for (int k = 0; k < 3; k++) write_reg(CfgIdxW'(RegUnused + k), '1);
    write_reg(RegPeakBurst, {13'h1FFF, 24'd1000});
    write_reg(RegCommittedBurst, 37'd400);
    write_reg(RegUpdateInterval, '1);
    offer_packet(32'd10, 16'd400);
    offer_packet(32'd20, 16'd1);
    offer_packet(32'd30, 16'd599);
    offer_packet(32'd40, 16'd1);
    offer_packet(32'd50, 16'd0);

    // refill with full-scale peak rate and a sub-byte-per-tick committed rate
    settle_pipeline();
    write_reg(RegPeakRate, '1);
    write_reg(RegCommittedRate, 37'd7999999);
    write_reg(RegUpdateInterval, '0);
    offer_packet(32'd51, 16'd100);
    offer_packet(32'd52, 16'd50);
    offer_packet(32'd52, 16'd1);
    offer_packet(32'hFFFF_FFFF, 16'hFFFF);
    offer_packet(32'd3, 16'd10);
    offer_packet(32'd1, 16'd10);

    settle_pipeline();
    write_reg(RegPeakRate, '0);
    write_reg(RegCommittedRate, '0);
    write_reg(RegPeakBurst, 37'hFF_FFFF);
    write_reg(RegCommittedBurst, 37'hFF_FFFF);
    offer_packet(32'd2, 16'hFFFF);
    offer_packet(32'd2, 16'h8000);
    offer_packet(32'd2, 16'h7FFF);

    settle_pipeline();
    write_reg(RegPeakBurst, '0);
    write_reg(RegPeakRate, '1);
    offer_packet(32'd100, 16'd1);
    offer_packet(32'd101, 16'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned      pkt_max;
    int unsigned      step_max;
    logic [TimeW-1:0] cur;
    logic [TimeW-1:0] t;
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_pipeline();
      src_gaps = (ph % 3 != 1);
      snk_gaps = (ph % 4 != 3);
      case (ph)
        0: begin
          write_reg(RegPeakRate, '1);
          write_reg(RegCommittedRate, '1);
          write_reg(RegPeakBurst, 37'hFF_FFFF);
          write_reg(RegCommittedBurst, 37'hFF_FFFF);
          write_reg(RegUpdateInterval, '0);
          pkt_max  = 65535;
          step_max = 3;
        end
        1: begin
          write_reg(RegPeakRate, '1);
          write_reg(RegCommittedRate, 37'd80000000000);
          write_reg(RegPeakBurst, 37'd200000);
          write_reg(RegCommittedBurst, 37'd100000);
          write_reg(RegUpdateInterval, '1);
          pkt_max  = 9000;
          step_max = 1000;
        end
        2: begin
          write_reg(RegPeakRate, '0);
          write_reg(RegCommittedRate, '0);
          write_reg(RegPeakBurst, 37'd262140);
          write_reg(RegCommittedBurst, '0);
          write_reg(RegUpdateInterval, '0);
          pkt_max  = 4096;
          step_max = 20;
        end
        default: program_profile(pkt_max, step_max);
      endcase
      cur = (ph % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 31) == 0) begin
          t = $urandom;
        end else begin
          cur = cur + $urandom_range(0, step_max);
          t   = cur;
        end
        offer_packet(t, ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(0, pkt_max)));
      end
    end
  endtask

  task automatic test_backpressure();
    int unsigned      pkt_max;
    int unsigned      step_max;
    logic [TimeW-1:0] cur;
    settle_pipeline();
    src_gaps = 1'b0;
    snk_gaps = 1'b1;
    program_profile(pkt_max, step_max);
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    cur = $urandom;
    for (int i = 0; i < 100; i++) begin
      cur = cur + $urandom_range(0, step_max);
      offer_packet(cur, 16'($urandom_range(0, pkt_max)));
    end
  endtask

  // sink side: random stall per transfer, plus one long hold on request
  initial begin
    color_out.ready = 1'b0;
    sink_wait       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        sink_wait = HoldCycles;
      end else if (sink_took) begin
        sink_took = 1'b0;
        sink_wait = snk_gaps ? $urandom_range(0, 6) : 0;
      end
      if (sink_wait != 0) begin
        color_out.ready <= 1'b0;
        sink_wait--;
      end else begin
        color_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && color_out.valid && color_out.ready) begin
      sink_took = 1'b1;
      if (pending_colors.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected color transfer: expected none, actual %0d",
                 $time, color_out.color);
      end else begin
        want_color = pending_colors.pop_front();
        if (color_out.color !== want_color) begin
          mismatches++;
          $display("%0t: color mismatch: expected %0d, actual %0d",
                   $time, want_color, color_out.color);
        end
      end
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((pkt_in.valid && pkt_in.ready) || (color_out.valid && color_out.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    pkt_in.valid        = 1'b0;
    pkt_in.now_ticks    = '0;
    pkt_in.packet_bytes = '0;
    peak_rate_q         = '0;
    committed_rate_q    = '0;
    peak_burst_q        = '0;
    committed_burst_q   = '0;
    interval_q          = '0;
    peak_tok_q          = '0;
    committed_tok_q     = '0;
    last_refill_q       = '0;
    mismatches          = 0;
    src_gaps            = 1'b1;
    snk_gaps            = 1'b1;
    hold_req            = 1'b0;
    sink_took           = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_color_marking();
    test_random_traffic();
    test_backpressure();
    settle_pipeline();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
hdl/trtcm_pkg.sv
hdl/trtcm_if.sv
hdl/trtcm_earn.sv
hdl/trtcm_marker.sv
hdl/trtcm_ofifo.sv
hdl/two_rate_three_color_marker_core.sv
tb/sv/tb_two_rate_three_color_marker_core.sv
